// File: rtl/rcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_pkg
// Shared types, codes and helpers of the chunk stream deframer.
// ----------------------------------------------------------------------------
package rcsd_pkg;

  localparam int unsigned DEF_NUM_CHANNELS  = 64;
  localparam int unsigned DEF_HANDSHAKE_LEN = 1536;

  localparam int unsigned HDR_BYTES = 11;
  localparam logic [23:0] MAX24     = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic REG_EXPECTED_VERSION   = 1'b0;
  localparam logic REG_INITIAL_CHUNK_SIZE = 1'b1;

  localparam logic [7:0]  RST_EXPECTED_VERSION   = 8'd3;
  localparam logic [23:0] RST_INITIAL_CHUNK_SIZE = 24'd128;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_EXTENDED = 2'd2;
  localparam logic [1:0] ERR_OVERRUN  = 2'd3;

  // Control message types that are consumed without output.
  localparam logic [7:0] MSG_SET_CHUNK_SIZE = 8'd1;
  localparam logic [7:0] MSG_ACK            = 8'd3;
  localparam logic [7:0] MSG_WINDOW_ACK     = 8'd5;

  localparam logic [1:0] FMT_NO_HEADER = 2'd3;

  typedef enum logic [5:0] {
    PH_VERSION = 6'b000001,
    PH_C1      = 6'b000010,
    PH_C2      = 6'b000100,
    PH_HEADER  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_ERROR   = 6'b100000
  } rcsd_phase_t;

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic [23:0] delta;
    logic [31:0] abs_time;
    logic [23:0] body_len;
    logic [7:0]  msg_type;
    logic [31:0] stream;
    logic [23:0] received;
    logic        in_msg;
  } rcsd_chan_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    rcsd_chan_t data;
  } rcsd_wr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [5:0]  channel;
    logic [7:0]  message_type;
    logic [31:0] timestamp;
    logic [31:0] stream_id;
    logic [23:0] message_length;
    logic        last_of_message;
    logic [1:0]  error_code;
  } rcsd_result_t;

  function automatic logic is_control(input logic [7:0] t);
    return (t == MSG_SET_CHUNK_SIZE) || (t == MSG_ACK) || (t == MSG_WINDOW_ACK);
  endfunction

  // New chunk size from a set-chunk-size body; zero keeps the old size.
  function automatic logic [23:0] apply_size(input logic [31:0] cw, input logic [23:0] size);
    logic [30:0] v;
    v = cw[30:0];
    if (v == '0) return size;
    if (v[30:24] != '0) return MAX24;
    return v[23:0];
  endfunction

  function automatic logic [3:0] header_need(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      2'd0:    n = 4'd11;
      2'd1:    n = 4'd7;
      2'd2:    n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rcsd_chan_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_chan_mem
// Per-channel state memory, registered read, write-first on a same-entry hit.
// ----------------------------------------------------------------------------
module rcsd_chan_mem #(
  parameter int unsigned NUM_CHANNELS = rcsd_pkg::DEF_NUM_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [5:0]           rd_addr,
  input  wire rcsd_pkg::rcsd_wr_t   wr,
  output rcsd_pkg::rcsd_chan_t      rd_data
);
  import rcsd_pkg::*;

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  rcsd_chan_t               mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  valid;
  rcsd_chan_t               rd_q;
  logic                     rd_valid;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            wa;
  logic                     hit;

  assign ra  = rd_addr[AW-1:0];
  assign wa  = wr.addr[AW-1:0];
  assign hit = wr.en && (wa == ra);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= hit ? wr.data : mem[ra];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= hit || valid[ra];
      end
      if (wr.en) begin
        valid[wa] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/rcsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_parser
// Version check, handshake skipping, chunk header parsing and payload tagging,
// one byte per step, with the active channel's state held in a working register.
// ----------------------------------------------------------------------------
module rcsd_parser #(
  parameter int unsigned NUM_CHANNELS  = rcsd_pkg::DEF_NUM_CHANNELS,
  parameter int unsigned HANDSHAKE_LEN = rcsd_pkg::DEF_HANDSHAKE_LEN
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [23:0]           cfg_data,
  input  wire logic                  step,
  input  wire logic [7:0]            b,
  input  wire rcsd_pkg::rcsd_chan_t  rd_data,
  output rcsd_pkg::rcsd_wr_t         wr,
  output logic                       res_valid,
  output rcsd_pkg::rcsd_result_t     res
);
  import rcsd_pkg::*;

  localparam int unsigned PCW = $clog2(HANDSHAKE_LEN + 1);
  localparam logic [PCW-1:0] HS_LEN = PCW'(HANDSHAKE_LEN);
  localparam logic [6:0] NCH = 7'(NUM_CHANNELS);

  logic [7:0]  exp_version;
  logic [23:0] init_size;

  rcsd_phase_t    phase, phase_next;
  logic [PCW-1:0] cnt, cnt_next;
  logic [3:0]     need, need_next;
  logic [3:0]     hlen, hlen_next;
  logic [7:0]     hb [HDR_BYTES];
  logic [5:0]     cur_ch, cur_ch_next;
  logic [23:0]    crem, crem_next;
  logic [23:0]    size, size_next;
  logic [31:0]    cw, cw_next;
  rcsd_chan_t     work, work_next;
  logic           hb_we;

  // Header bytes including the one arriving now.
  logic [7:0]  hb_now [HDR_BYTES];
  logic        basic;
  logic [3:0]  need_f;
  rcsd_chan_t  base, fin;
  logic        fin_err;
  logic [1:0]  fin_code;
  logic [31:0] fin_cw;
  logic [23:0] fin_size, fin_chunk, rem, cap, t24;
  logic        fin_zero;

  assign basic  = (need == 4'd0) && (hlen == 4'd0);
  assign need_f = basic ? 4'd0 : need;

  always_comb begin
    hb_now = hb;
    if (hlen < 4'(HDR_BYTES)) begin
      hb_now[hlen] = b;
    end
  end

  always_comb begin
    base     = basic ? rd_data : work;
    fin      = base;
    fin_err  = 1'b0;
    fin_code = ERR_NONE;
    fin_cw   = cw;
    t24      = {hb_now[0], hb_now[1], hb_now[2]};
    if (need_f >= 4'd3) begin
      if (t24 == MAX24) begin
        fin_err  = 1'b1;
        fin_code = ERR_EXTENDED;
      end
      fin.delta = t24;
    end
    if (need_f >= 4'd7) begin
      fin.body_len = {hb_now[3], hb_now[4], hb_now[5]};
      fin.msg_type = hb_now[6];
    end
    if (need_f >= 4'd11) begin
      fin.stream = {hb_now[10], hb_now[9], hb_now[8], hb_now[7]};
    end
    if (!base.in_msg) begin
      fin.received = '0;
      fin.abs_time = (need_f >= 4'd11) ? {8'd0, fin.delta}
                                       : base.abs_time + {8'd0, fin.delta};
      fin.in_msg   = 1'b1;
      fin_cw       = '0;
    end else if (base.received > fin.body_len && !fin_err) begin
      fin_err  = 1'b1;
      fin_code = ERR_OVERRUN;
    end
    rem      = fin.body_len - fin.received;
    fin_zero = (rem == '0);
    if (fin_zero) begin
      fin.in_msg = 1'b0;
    end
    cap       = (size == '0) ? 24'd1 : size;
    fin_chunk = (rem < cap) ? rem : cap;
    fin_size  = (fin_zero && fin.msg_type == MSG_SET_CHUNK_SIZE) ? apply_size(fin_cw, size)
                                                                 : size;
  end

  always_comb begin
    logic [PCW-1:0] cnt_inc;
    logic [3:0]     hlen_inc;
    logic           fin_go;
    logic           err_go;
    logic [1:0]     err_code;
    logic           emit_go;
    logic [1:0]     emit_kind;
    logic           emit_last;
    rcsd_chan_t     pw;
    logic [31:0]    cw_p;
    logic [23:0]    crem_dec;
    logic           plast;

    phase_next  = phase;
    cnt_next    = cnt;
    need_next   = need;
    hlen_next   = hlen;
    cur_ch_next = cur_ch;
    crem_next   = crem;
    size_next   = size;
    cw_next     = cw;
    work_next   = work;
    hb_we       = 1'b0;
    wr          = '0;
    res_valid   = 1'b0;
    res         = '0;
    fin_go      = 1'b0;
    err_go      = 1'b0;
    err_code    = ERR_NONE;
    emit_go     = 1'b0;
    emit_kind   = KIND_PAYLOAD;
    emit_last   = 1'b0;
    cnt_inc     = cnt + 1'b1;
    hlen_inc    = hlen + 4'd1;
    pw          = work;
    cw_p        = cw;
    crem_dec    = crem - 24'd1;
    plast       = 1'b0;

    if (step) begin
      unique case (phase)
        PH_VERSION: begin
          if (b != exp_version) begin
            err_go   = 1'b1;
            err_code = ERR_VERSION;
          end else begin
            size_next  = init_size;
            phase_next = PH_C1;
            cnt_next   = '0;
          end
        end
        PH_C1, PH_C2: begin
          if (cnt_inc >= HS_LEN) begin
            phase_next = (phase == PH_C1) ? PH_C2 : PH_HEADER;
            cnt_next   = '0;
            hlen_next  = '0;
            need_next  = '0;
          end else begin
            cnt_next = cnt_inc;
          end
        end
        PH_HEADER: begin
          if (basic) begin
            if ({1'b0, b[5:0]} < 7'd2 || {1'b0, b[5:0]} >= NCH) begin
              err_go   = 1'b1;
              err_code = ERR_EXTENDED;
            end else begin
              cur_ch_next = b[5:0];
              work_next   = rd_data;
              need_next   = header_need(b[7:6]);
              fin_go      = (b[7:6] == FMT_NO_HEADER);
            end
          end else begin
            hb_we     = (hlen < 4'(HDR_BYTES));
            hlen_next = hlen_inc;
            if (hlen_inc >= need) begin
              fin_go    = 1'b1;
              hlen_next = '0;
              need_next = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (work.received < 24'd4) begin
            cw_p = {cw[23:0], b};
          end
          pw.received = work.received + 24'd1;
          plast       = (pw.received == work.body_len);
          if (plast) begin
            pw.in_msg = 1'b0;
          end
          cw_next   = cw_p;
          crem_next = crem_dec;
          if (crem_dec == '0) begin
            phase_next = PH_HEADER;
            need_next  = '0;
            hlen_next  = '0;
          end
          work_next = pw;
          wr.en     = 1'b1;
          wr.addr   = cur_ch;
          wr.data   = pw;
          if (is_control(work.msg_type)) begin
            if (plast && work.msg_type == MSG_SET_CHUNK_SIZE) begin
              size_next = apply_size(cw_p, size);
            end
          end else begin
            emit_go   = 1'b1;
            emit_kind = KIND_PAYLOAD;
            emit_last = plast;
          end
        end
        PH_ERROR: begin
        end
        default: begin
        end
      endcase

      if (fin_go) begin
        if (fin_err) begin
          err_go   = 1'b1;
          err_code = fin_code;
        end else begin
          work_next = fin;
          cw_next   = fin_cw;
          size_next = fin_size;
          wr.en     = 1'b1;
          wr.addr   = cur_ch_next;
          wr.data   = fin;
          if (fin_zero) begin
            phase_next = PH_HEADER;
            if (!is_control(fin.msg_type)) begin
              emit_go   = 1'b1;
              emit_kind = KIND_EMPTY;
              emit_last = 1'b1;
            end
          end else begin
            crem_next  = fin_chunk;
            phase_next = PH_PAYLOAD;
          end
        end
      end

      if (err_go) begin
        phase_next     = PH_ERROR;
        wr             = '0;
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
      end else if (emit_go) begin
        res_valid           = 1'b1;
        res.kind            = emit_kind;
        res.payload_byte    = (emit_kind == KIND_PAYLOAD) ? b : 8'd0;
        res.channel         = cur_ch_next;
        res.message_type    = work_next.msg_type;
        res.timestamp       = work_next.abs_time;
        res.stream_id       = work_next.stream;
        res.message_length  = work_next.body_len;
        res.last_of_message = emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_version <= RST_EXPECTED_VERSION;
      init_size   <= RST_INITIAL_CHUNK_SIZE;
      phase       <= PH_VERSION;
      cnt         <= '0;
      need        <= '0;
      hlen        <= '0;
      cur_ch      <= '0;
      crem        <= '0;
      size        <= RST_INITIAL_CHUNK_SIZE;
      cw          <= '0;
      work        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_EXPECTED_VERSION:   exp_version <= cfg_data[7:0];
          REG_INITIAL_CHUNK_SIZE: init_size   <= cfg_data;
          default: begin
          end
        endcase
      end
      phase  <= phase_next;
      cnt    <= cnt_next;
      need   <= need_next;
      hlen   <= hlen_next;
      cur_ch <= cur_ch_next;
      crem   <= crem_next;
      size   <= size_next;
      cw     <= cw_next;
      work   <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hb_we) begin
      hb[hlen] <= b;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rtmp_chunk_stream_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: the channel memory is read at the edge at which a byte transfers in;
// the byte's result is registered on the output when its parse step runs.
// Throughput: one byte per cycle while results are taken; a byte waits in the
// input stage whenever the output register holds a result not yet taken.
// Reset: rst is synchronous; it clears the parser, the channel valid bits and
// both pipeline stages, and restores both configuration registers.
// ----------------------------------------------------------------------------
// rtmp_chunk_stream_deframer
// Receive-side chunk stream deframer: version check, handshake skip, chunk
// header parsing and tagged payload output.
// ----------------------------------------------------------------------------
module rtmp_chunk_stream_deframer #(
  parameter int unsigned NUM_CHANNELS  = rcsd_pkg::DEF_NUM_CHANNELS,
  parameter int unsigned HANDSHAKE_LEN = rcsd_pkg::DEF_HANDSHAKE_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [5:0]       channel,
  output logic [7:0]       message_type,
  output logic [31:0]      timestamp,
  output logic [31:0]      stream_id,
  output logic [23:0]      message_length,
  output logic             last_of_message,
  output logic [1:0]       error_code
);
  import rcsd_pkg::*;

  // Input stage: the byte waits here while its channel entry is read. The
  // low six bits are used as the read address on every transfer, so that a
  // byte that turns out to be a basic header finds its channel state ready.
  logic         a_valid;
  logic [7:0]   a_byte;
  logic         a_fire;
  logic         in_fire;

  rcsd_chan_t   rd_data;
  rcsd_wr_t     wr;
  logic         res_valid;
  rcsd_result_t res;
  rcsd_result_t out_q;

  // The parse step runs only when the output register can take a result,
  // whether or not this byte produces one.
  assign a_fire   = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || a_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte <= data_byte;
    end
  end

  // A write from the parse step and a read for the next byte may hit the
  // same entry at one edge; the memory forwards the written value.
  rcsd_chan_mem #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_fire),
    .rd_addr(data_byte[5:0]),
    .wr     (wr),
    .rd_data(rd_data)
  );

  rcsd_parser #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .HANDSHAKE_LEN(HANDSHAKE_LEN)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (a_fire),
    .b        (a_byte),
    .rd_data  (rd_data),
    .wr       (wr),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register: holds one result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign kind            = out_q.kind;
  assign payload_byte    = out_q.payload_byte;
  assign channel         = out_q.channel;
  assign message_type    = out_q.message_type;
  assign timestamp       = out_q.timestamp;
  assign stream_id       = out_q.stream_id;
  assign message_length  = out_q.message_length;
  assign last_of_message = out_q.last_of_message;
  assign error_code      = out_q.error_code;

  // An error result always carries a code, and no other result does.
  a_err_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // An empty-message result always closes its message.
  a_empty_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_EMPTY) |-> last_of_message)
    else $error("empty-message result without last mark");

  // Channel state is never written for the reserved low channel ids.
  a_wr_chan : assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr >= 6'd2))
    else $error("channel memory written for a reserved channel id");

  // The parse step never runs while a result is stuck in the output register.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !a_fire)
    else $error("parse step ran while output was stalled");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk stream deframer: a byte-level parser
// model predicts every result, a directed chunk sequence and random chunk
// traffic are pushed through, and the results are compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import rcsd_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 5000;
  // Extra wait after every expected result has been taken.
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 225;

  // Parser states of the bench's own model.
  typedef enum logic [5:0] {
    S_VER = 6'b000001,
    S_C1  = 6'b000010,
    S_C2  = 6'b000100,
    S_HDR = 6'b001000,
    S_PAY = 6'b010000,
    S_ERR = 6'b100000
  } parse_state_t;

  typedef struct {
    logic [7:0]   b;
    bit           typed;
    rcsd_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_EXPECTED_VERSION;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [5:0]  channel;
  logic [7:0]  message_type;
  logic [31:0] timestamp;
  logic [31:0] stream_id;
  logic [23:0] message_length;
  logic        last_of_message;
  logic [1:0]  error_code;

  rtmp_chunk_stream_deframer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .payload_byte(payload_byte), .channel(channel),
    .message_type(message_type), .timestamp(timestamp), .stream_id(stream_id),
    .message_length(message_length), .last_of_message(last_of_message),
    .error_code(error_code)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model. Its register copies track the configuration port; the
  // chunk size register only matters when the version byte is taken.
  // --------------------------------------------------------------------------
  logic [7:0]   ver_reg;
  logic [23:0]  size_reg;
  parse_state_t pstate;
  int unsigned  pcount;
  logic [7:0]   hdr[HDR_BYTES];
  int unsigned  hdr_len;
  logic [5:0]   cur_ch;
  logic [23:0]  chunk_left;
  logic [23:0]  chunk_size;
  logic [31:0]  ctl_word;
  logic [23:0]  ch_delta[64];
  logic [31:0]  ch_time[64];
  logic [23:0]  ch_len[64];
  logic [7:0]   ch_type[64];
  logic [31:0]  ch_sid[64];
  logic [23:0]  ch_rcvd[64];
  bit           ch_busy[64];

  // Set-chunk-size value that the generator puts into each channel's body.
  logic [31:0]  size_msg_val[64];

  rcsd_result_t results_due[$];
  logic [7:0]   bytes_to_send[$];
  dir_row_t     dir_tab[$];
  int unsigned  fed_count;
  int unsigned  fail_count = 0;

  function automatic rcsd_result_t make_res(logic [1:0] k, logic [7:0] pb, logic [5:0] ch,
                                            logic [7:0] ty, logic [31:0] ts, logic [31:0] sid,
                                            logic [23:0] len, logic lst, logic [1:0] ec);
    rcsd_result_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.channel = ch;
    r.message_type = ty;
    r.timestamp = ts;
    r.stream_id = sid;
    r.message_length = len;
    r.last_of_message = lst;
    r.error_code = ec;
    return r;
  endfunction

  // Queue helpers: each appends at the tail.
  task automatic queue_result(input rcsd_result_t r);
    results_due.insert(results_due.size(), r);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    bytes_to_send.insert(bytes_to_send.size(), b);
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed, input rcsd_result_t res);
    dir_row_t row;
    row.b = b;
    row.typed = typed;
    row.res = res;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  function automatic rcsd_result_t raise_err(logic [1:0] code);
    pstate = S_ERR;
    return make_res(KIND_ERROR, '0, '0, '0, '0, '0, '0, 1'b0, code);
  endfunction

  function automatic rcsd_result_t tag_result(logic [1:0] k, logic [7:0] pb, logic lst);
    return make_res(k, pb, cur_ch, ch_type[cur_ch], ch_time[cur_ch], ch_sid[cur_ch],
                    ch_len[cur_ch], lst, ERR_NONE);
  endfunction

  // Sizes above 24 bits saturate, zero keeps the old size, bit 31 is ignored.
  function automatic void take_chunk_size();
    logic [30:0] v;
    v = ctl_word[30:0];
    if (v != '0) chunk_size = (v > 31'(MAX24)) ? MAX24 : v[23:0];
  endfunction

  function automatic bit control_type(logic [7:0] t);
    return t == MSG_SET_CHUNK_SIZE || t == MSG_ACK || t == MSG_WINDOW_ACK;
  endfunction

  // Applies the collected header bytes to the current channel.
  task automatic close_header(output bit got, output rcsd_result_t r);
    logic [5:0]  c;
    logic [23:0] t;
    logic [23:0] rem;
    logic [23:0] cap;
    c = cur_ch;
    got = 1'b0;
    if (pcount >= 3) begin
      t = {hdr[0], hdr[1], hdr[2]};
      if (t == MAX24) begin
        r = raise_err(ERR_EXTENDED);
        got = 1'b1;
        return;
      end
      ch_delta[c] = t;
      if (pcount >= 7) begin
        ch_len[c] = {hdr[3], hdr[4], hdr[5]};
        ch_type[c] = hdr[6];
        if (pcount >= 11) ch_sid[c] = {hdr[10], hdr[9], hdr[8], hdr[7]};
      end
    end
    if (!ch_busy[c]) begin
      // A new message: full headers restart the clock, others add the delta.
      ch_rcvd[c] = '0;
      ch_time[c] = (pcount >= 11) ? 32'(ch_delta[c]) : ch_time[c] + 32'(ch_delta[c]);
      ch_busy[c] = 1'b1;
      ctl_word = '0;
    end else if (ch_rcvd[c] > ch_len[c]) begin
      r = raise_err(ERR_OVERRUN);
      got = 1'b1;
      return;
    end
    rem = ch_len[c] - ch_rcvd[c];
    if (rem == '0) begin
      ch_busy[c] = 1'b0;
      pstate = S_HDR;
      if (control_type(ch_type[c])) begin
        if (ch_type[c] == MSG_SET_CHUNK_SIZE) take_chunk_size();
      end else begin
        r = tag_result(KIND_EMPTY, '0, 1'b1);
        got = 1'b1;
      end
      return;
    end
    cap = (chunk_size == '0) ? 24'd1 : chunk_size;
    chunk_left = (rem < cap) ? rem : cap;
    pstate = S_PAY;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got, output rcsd_result_t r);
    logic [5:0] c;
    logic       lst;
    got = 1'b0;
    r = '0;
    case (pstate)
      S_VER: begin
        if (b != ver_reg) begin
          r = raise_err(ERR_VERSION);
          got = 1'b1;
        end else begin
          chunk_size = size_reg;
          pstate = S_C1;
          pcount = 0;
        end
      end
      S_C1, S_C2: begin
        pcount++;
        if (pcount >= DEF_HANDSHAKE_LEN) begin
          pstate = (pstate == S_C1) ? S_C2 : S_HDR;
          pcount = 0;
          hdr_len = 0;
        end
      end
      S_HDR: begin
        if (hdr_len == 0 && pcount == 0) begin
          // Basic header: format in the top two bits, channel below.
          if (b[5:0] < 2) begin
            r = raise_err(ERR_EXTENDED);
            got = 1'b1;
          end else begin
            cur_ch = b[5:0];
            pcount = header_need(b[7:6]);
            if (pcount == 0) close_header(got, r);
          end
        end else begin
          if (hdr_len < HDR_BYTES) hdr[hdr_len] = b;
          hdr_len++;
          if (hdr_len >= pcount) begin
            close_header(got, r);
            hdr_len = 0;
            pcount = 0;
          end
        end
      end
      S_PAY: begin
        c = cur_ch;
        if (ch_rcvd[c] < 4) ctl_word = {ctl_word[23:0], b};
        ch_rcvd[c] = ch_rcvd[c] + 24'd1;
        lst = (ch_rcvd[c] == ch_len[c]);
        chunk_left--;
        if (chunk_left == '0) begin
          pstate = S_HDR;
          pcount = 0;
          hdr_len = 0;
        end
        if (lst) ch_busy[c] = 1'b0;
        if (control_type(ch_type[c])) begin
          if (lst && ch_type[c] == MSG_SET_CHUNK_SIZE) take_chunk_size();
        end else begin
          r = tag_result(KIND_PAYLOAD, b, lst);
          got = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Runs a byte through the model and queues it and its expected result.
  task automatic feed(input logic [7:0] b);
    bit           got;
    rcsd_result_t r;
    parse_byte(b, got, r);
    if (got) queue_result(r);
    queue_byte(b);
    fed_count++;
  endtask

  task automatic send_header(input logic [5:0] c, input logic [1:0] fmt, input logic [23:0] ts,
                             input logic [23:0] len, input logic [7:0] ty,
                             input logic [31:0] sid);
    feed({fmt, c});
    if (fmt != FMT_NO_HEADER) begin
      feed(ts[23:16]); feed(ts[15:8]); feed(ts[7:0]);
    end
    if (fmt <= 2'd1) begin
      feed(len[23:16]); feed(len[15:8]); feed(len[7:0]); feed(ty);
    end
    if (fmt == 2'd0) begin
      feed(sid[7:0]); feed(sid[15:8]); feed(sid[23:16]); feed(sid[31:24]);
    end
  endtask

  // Fills the chunk that the last header opened; set-chunk-size bodies
  // carry the chosen size in their first four bytes.
  task automatic send_body();
    logic [31:0] v;
    while (pstate == S_PAY) begin
      v = size_msg_val[cur_ch];
      if (ch_type[cur_ch] == MSG_SET_CHUNK_SIZE && ch_rcvd[cur_ch] < 4)
        feed(v[8 * (3 - ch_rcvd[cur_ch]) +: 8]);
      else
        feed(8'($urandom));
    end
  endtask

  function automatic logic [23:0] pick_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'hFFFFFE;
      default: return 24'($urandom_range(0, 24'hFFFFFE));
    endcase
  endfunction

  function automatic logic [31:0] pick_size_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000005;
      3: return $urandom;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // Random chunk traffic on a few busy channels plus scattered ones.
  // Channels 40 and 41 are kept clear for the closing sequence.
  task automatic gen_traffic(input int unsigned nbytes);
    int unsigned stop_at;
    logic [5:0]  c;
    logic [1:0]  fmt;
    logic [23:0] len;
    logic [7:0]  ty;
    stop_at = fed_count + nbytes;
    while (fed_count < stop_at) begin
      case ($urandom_range(0, 3))
        0: c = 6'd2;
        1: c = 6'd3;
        2: c = 6'd63;
        default: c = 6'($urandom_range(4, 39));
      endcase
      ty = ($urandom_range(0, 99) < 15) ? (($urandom_range(0, 2) == 0) ? MSG_SET_CHUNK_SIZE :
           ($urandom_range(0, 1) ? MSG_ACK : MSG_WINDOW_ACK)) : 8'($urandom);
      if ($urandom_range(0, 19) == 0) len = '0;
      else if ($urandom_range(0, 9) == 0) len = 24'($urandom_range(13, 60));
      else len = 24'($urandom_range(1, 12));
      if (ch_busy[c]) begin
        // Continue the pending message; a type 1 header may grow the length.
        case ($urandom_range(0, 9))
          0, 1: fmt = 2'd2;
          2: begin
            fmt = 2'd1;
            len = ch_rcvd[c] + 24'($urandom_range(0, 6));
          end
          default: fmt = FMT_NO_HEADER;
        endcase
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: fmt = 2'd0;
          8, 9, 10, 11, 12: fmt = 2'd1;
          13, 14, 15: fmt = 2'd2;
          default: fmt = FMT_NO_HEADER;
        endcase
      end
      if (fmt <= 2'd1 && ty == MSG_SET_CHUNK_SIZE) size_msg_val[c] = pick_size_value();
      send_header(c, fmt, pick_time(), len, ty, $urandom);
      send_body();
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: random gaps, mostly short, with gap-free stretches.
  // --------------------------------------------------------------------------
  task automatic drive_bytes();
    int unsigned gap;
    int unsigned run_left;
    bit          quiet;
    run_left = 0;
    quiet = 1'b0;
    while (bytes_to_send.size() > 0) begin
      if (run_left == 0) begin
        run_left = $urandom_range(16, 96);
        quiet = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      gap = 0;
      if (!quiet) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
          6: gap = $urandom_range(10, 40);
          default: gap = 0;
        endcase
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= bytes_to_send.pop_front();
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  // Waits for every expected result, then for the pipeline to empty.
  task automatic drain();
    while (results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write per call; the enable drops again before the next one.
  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_EXPECTED_VERSION) ver_reg = val[7:0];
    else size_reg = val;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random backpressure with occasional long stalls.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 39))
        0: begin
          stall_left <= $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
        1, 2, 3, 4, 5, 6: begin
          stall_left <= $urandom_range(0, 2);
          out_ready <= 1'b0;
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    rcsd_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transfer: kind %0d channel %0d", kind, channel);
        fail_count++;
      end else begin
        w = results_due.pop_front();
        check_field("kind", 32'(w.kind), 32'(kind));
        check_field("payload_byte", 32'(w.payload_byte), 32'(payload_byte));
        check_field("channel", 32'(w.channel), 32'(channel));
        check_field("message_type", 32'(w.message_type), 32'(message_type));
        check_field("timestamp", w.timestamp, timestamp);
        check_field("stream_id", w.stream_id, stream_id);
        check_field("message_length", 32'(w.message_length), 32'(message_length));
        check_field("last_of_message", 32'(w.last_of_message), 32'(last_of_message));
        check_field("error_code", 32'(w.error_code), 32'(error_code));
      end
    end
  end

  // Hang detection: any transfer on either side restarts the count.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t    row;
    bit          got;
    rcsd_result_t r;
    logic [23:0] ts_pick;

    // Model reset state.
    ver_reg = RST_EXPECTED_VERSION;
    size_reg = RST_INITIAL_CHUNK_SIZE;
    pstate = S_VER;
    pcount = 0;
    hdr_len = 0;
    cur_ch = '0;
    chunk_left = '0;
    chunk_size = RST_INITIAL_CHUNK_SIZE;
    ctl_word = '0;
    fed_count = 0;
    foreach (ch_busy[i]) begin
      ch_delta[i] = '0;
      ch_time[i] = '0;
      ch_len[i] = '0;
      ch_type[i] = '0;
      ch_sid[i] = '0;
      ch_rcvd[i] = '0;
      ch_busy[i] = 1'b0;
      size_msg_val[i] = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Top version value and a tiny chunk size so that messages split.
    write_reg(REG_EXPECTED_VERSION, 24'hFF);
    write_reg(REG_INITIAL_CHUNK_SIZE, 24'd3);

    // Version byte, then both handshake blocks with random content.
    feed(8'hFF);
    repeat (2 * DEF_HANDSHAKE_LEN) feed(8'($urandom));

    // Directed chunks. Full header on channel 2: time 0x10, length 3,
    // type 8, stream id 0x80000001 little-endian, then bytes 00 FF AA
    // in one chunk of exactly the chunk size.
    add_row(8'h02, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h10, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h03, 1'b0, '0);
    add_row(8'h08, 1'b0, '0);
    add_row(8'h01, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h80, 1'b0, '0);
    add_row(8'h00, 1'b1, make_res(KIND_PAYLOAD, 8'h00, 6'd2, 8'd8, 32'h10,
                                  32'h80000001, 24'd3, 1'b0, ERR_NONE));
    add_row(8'hFF, 1'b1, make_res(KIND_PAYLOAD, 8'hFF, 6'd2, 8'd8, 32'h10,
                                  32'h80000001, 24'd3, 1'b0, ERR_NONE));
    add_row(8'hAA, 1'b1, make_res(KIND_PAYLOAD, 8'hAA, 6'd2, 8'd8, 32'h10,
                                  32'h80000001, 24'd3, 1'b1, ERR_NONE));
    // Type 1 header on the highest channel with an empty body: the message
    // completes at once with the delta added to a zero start time.
    add_row(8'h7F, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h05, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h09, 1'b1, make_res(KIND_EMPTY, 8'h00, 6'd63, 8'd9, 32'd5,
                                  32'd0, 24'd0, 1'b1, ERR_NONE));
    // Bare continuation header: a new empty message, delta added again.
    add_row(8'hFF, 1'b1, make_res(KIND_EMPTY, 8'h00, 6'd63, 8'd9, 32'd10,
                                  32'd0, 24'd0, 1'b1, ERR_NONE));
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      parse_byte(row.b, got, r);
      if (row.typed) queue_result(row.res);
      else if (got) queue_result(r);
      queue_byte(row.b);
    end

    gen_traffic(RANDOM_BYTES);
    drive_bytes();
    drain();

    // New register values only act at a version byte, which never comes
    // again; the model tracks them all the same.
    write_reg(REG_EXPECTED_VERSION, 24'h00);
    write_reg(REG_INITIAL_CHUNK_SIZE, MAX24);
    gen_traffic(RANDOM_BYTES);
    drive_bytes();
    drain();

    write_reg(REG_INITIAL_CHUNK_SIZE, 24'd1);
    write_reg(REG_EXPECTED_VERSION, 24'h80);

    // Closing sequence: force a chunk size of two on a spare channel, then
    // raise one sticky error and show that later bytes give nothing.
    size_msg_val[40] = 32'd2;
    send_header(6'd40, 2'd0, 24'd0, 24'd4, MSG_SET_CHUNK_SIZE, '0);
    send_body();
    while (ch_busy[40]) begin
      send_header(6'd40, FMT_NO_HEADER, '0, '0, '0, '0);
      send_body();
    end
    case ($urandom_range(0, 2))
      0: feed({2'($urandom), 5'd0, 1'($urandom)});
      1: send_header(6'd3, 2'd2, MAX24, '0, '0, '0);
      default: begin
        // Two of ten body bytes arrive, then a shorter length is declared.
        send_header(6'd41, 2'd0, 24'd7, 24'd10, 8'd8, 32'd41);
        send_body();
        send_header(6'd41, 2'd1, 24'd7, 24'd1, 8'd8, '0);
      end
    endcase
    repeat (6) begin
      ts_pick = pick_time();
      feed(ts_pick[7:0]);
    end
    drive_bytes();
    drain();

    if (fail_count == 0 && results_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: rtmp_chunk_stream_deframer.f
rtl/rcsd_pkg.sv
rtl/rcsd_chan_mem.sv
rtl/rcsd_parser.sv
rtl/rtmp_chunk_stream_deframer.sv
tb/sv/tb.sv
